// ===== src/lzw_pkg.sv =====
`timescale 1ns / 1ps

package lzw_pkg;

  // Code width and the widths that follow from it.
  localparam int CODE_BITS   = 12;
  localparam int PIX_BITS    = 8;
  localparam int ROOT_W      = 4;
  localparam int KEY_BITS    = CODE_BITS + PIX_BITS;
  localparam int FREE_BITS   = CODE_BITS + 1;

  // The hash table has twice as many slots as there are codes, so a probe
  // sequence always ends at an empty slot.
  localparam int HASH_BITS   = CODE_BITS + 1;
  localparam int HASH_DEPTH  = 1 << HASH_BITS;

  // Each slot carries the image epoch that wrote it; epoch zero means empty.
  localparam int EPOCH_BITS  = 4;
  localparam int ENTRY_BITS  = EPOCH_BITS + KEY_BITS + CODE_BITS;

  localparam logic [EPOCH_BITS-1:0] EPOCH_EMPTY = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  localparam logic [ROOT_W-1:0] ROOT_MIN   = ROOT_W'(2);
  localparam logic [ROOT_W-1:0] ROOT_MAX   = ROOT_W'(8);
  localparam logic [ROOT_W-1:0] ROOT_RESET = ROOT_W'(8);

  // Output queue.
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = 2;
  localparam int OUT_CNT_BITS = 3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_FLUSH,
    S_END
  } state_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last_code;
  } code_word_t;

  typedef struct packed {
    logic       valid;
    code_word_t word;
  } word_push_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [KEY_BITS-1:0]   key;
    logic [CODE_BITS-1:0]  code;
  } dict_entry_t;

  function automatic logic [ROOT_W-1:0] clamp_root(input logic [ROOT_W-1:0] r);
    logic [ROOT_W-1:0] res;
    if (r < ROOT_MIN) begin
      res = ROOT_MIN;
    end else if (r > ROOT_MAX) begin
      res = ROOT_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [PIX_BITS-1:0] pix_mask(input logic [ROOT_W-1:0] r);
    logic [PIX_BITS-1:0] m;
    m = ~({PIX_BITS{1'b1}} << r);
    return m;
  endfunction

  function automatic logic [HASH_BITS-1:0] dict_hash(input logic [CODE_BITS-1:0] prefix,
                                                     input logic [PIX_BITS-1:0]  pix);
    logic [HASH_BITS-1:0] h;
    h = HASH_BITS'(prefix) ^ (HASH_BITS'(pix) << (HASH_BITS - PIX_BITS));
    return h;
  endfunction

endpackage

// ===== src/lzw_if.sv =====
`timescale 1ns / 1ps

interface lzw_pix_if;
  logic                          valid;
  logic                          ready;
  logic [lzw_pkg::PIX_BITS-1:0]  pixel_index;
  logic                          last_pixel;

  modport source(output valid, output pixel_index, output last_pixel, input ready);
  modport sink(input valid, input pixel_index, input last_pixel, output ready);
endinterface

interface lzw_code_if;
  logic                          valid;
  logic                          ready;
  logic [lzw_pkg::CODE_BITS-1:0] code;
  logic                          last_code;

  modport source(output valid, output code, output last_code, input ready);
  modport sink(input valid, input code, input last_code, output ready);
endinterface

// ===== src/lzw_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lzw_out_fifo.sv =====
`timescale 1ns / 1ps

// Small queue between the encoder and the code channel.
module lzw_out_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  lzw_pkg::word_push_t                push,
  output logic [lzw_pkg::OUT_CNT_BITS-1:0]   level,
  lzw_code_if.source                         out
);

  lzw_pkg::code_word_t                  mem [lzw_pkg::OUT_DEPTH];
  logic [lzw_pkg::OUT_PTR_BITS-1:0]     wr_ptr;
  logic [lzw_pkg::OUT_PTR_BITS-1:0]     rd_ptr;
  logic [lzw_pkg::OUT_CNT_BITS-1:0]     count;
  logic                                 pop;

  assign out.valid     = (count != '0);
  assign out.code      = mem[rd_ptr].code;
  assign out.last_code = mem[rd_ptr].last_code;
  assign pop           = out.valid && out.ready;
  assign level         = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.word;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.valid && count == lzw_pkg::OUT_CNT_BITS'(lzw_pkg::OUT_DEPTH)) |-> pop)
    else $error("code queue overflow");
`endif

endmodule

// ===== src/lzw_code_stream_encoder.sv =====
`timescale 1ns / 1ps

// GIF-style LZW code stream encoder with CODE_BITS-bit codes. Each pixel word
// carries a color index and a last-of-image flag; each code word carries one
// code and a flag that marks the end-of-information code closing the image.
// The first pixel of an image emits the clear code (2^root_bits, with
// root_bits clamped to 2..8 and sampled at that pixel); the last pixel emits
// the final prefix code and then the end code. The string dictionary lives
// in one hash table RAM of 2^(CODE_BITS+1) slots, searched by linear
// probing. A pixel is accepted in the idle state and then probes one slot
// at a time, passing every occupied slot with a different string; no new
// pixel is accepted until a slot decides it. The first pixel of an image
// needs no probe; the last pixel then emits its two codes from the flush
// and end states. The hash table RAM's single read port sets this pace.
// Slots are tagged with an image epoch instead of being wiped per image;
// after reset, and after every fifteenth image, the block clears all
// 2^(CODE_BITS+1) slots (8192 at 12-bit codes) and accepts no pixels
// meanwhile. Writes to root_bits are taken at any time and act at the next
// image start. Up to four code words are queued toward the output, and a new
// pixel waits while more than one code word is still queued.
module lzw_code_stream_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lzw_pkg::ROOT_W-1:0]  cfg_data,
  lzw_pix_if.sink                     pix,
  lzw_code_if.source                  codes
);

  // Control state.
  lzw_pkg::state_t                       state, state_next;
  logic                                  in_image, in_image_next;
  logic [lzw_pkg::EPOCH_BITS-1:0]        epoch, epoch_next;
  logic [lzw_pkg::HASH_BITS-1:0]         clear_addr, clear_addr_next;
  logic [lzw_pkg::FREE_BITS-1:0]         next_free, next_free_next;
  logic [lzw_pkg::CODE_BITS-1:0]         prefix, prefix_next;
  logic [lzw_pkg::ROOT_W-1:0]            root_bits;

  // Per-item working registers.
  logic [lzw_pkg::ROOT_W-1:0]            img_root, img_root_next;
  logic [lzw_pkg::PIX_BITS-1:0]          cur_pix, cur_pix_next;
  logic                                  last_pending, last_pending_next;
  logic [lzw_pkg::HASH_BITS-1:0]         probe_addr, probe_addr_next;

  // Hash table port signals.
  logic                                  ram_we;
  logic [lzw_pkg::HASH_BITS-1:0]         ram_waddr;
  lzw_pkg::dict_entry_t                  ram_wdata;
  logic [lzw_pkg::HASH_BITS-1:0]         ram_raddr;
  logic [lzw_pkg::ENTRY_BITS-1:0]        ram_rdata;
  lzw_pkg::dict_entry_t                  slot;

  // Output queue.
  lzw_pkg::word_push_t                   push;
  logic [lzw_pkg::OUT_CNT_BITS-1:0]      level;

  // Derived values.
  logic [lzw_pkg::ROOT_W-1:0]            root_now;
  logic [lzw_pkg::CODE_BITS-1:0]         clear_code;
  logic [lzw_pkg::PIX_BITS-1:0]          pix_masked;
  logic [lzw_pkg::KEY_BITS-1:0]          probe_key;
  logic                                  accept;
  logic                                  slot_used;
  logic                                  table_full;

  assign slot = lzw_pkg::dict_entry_t'(ram_rdata);

  // The root size is frozen for the length of an image.
  assign root_now   = in_image ? img_root : lzw_pkg::clamp_root(root_bits);
  assign clear_code = lzw_pkg::CODE_BITS'(1) << root_now;
  assign pix_masked = pix.pixel_index & lzw_pkg::pix_mask(root_now);
  assign probe_key  = {prefix, cur_pix};
  assign slot_used  = (slot.epoch == epoch);
  assign table_full = next_free[lzw_pkg::CODE_BITS];

  // A pixel may produce three code words, so new pixels wait until the
  // queue has room for all of them.
  assign pix.ready = (state == lzw_pkg::S_IDLE) &&
                     (level <= lzw_pkg::OUT_CNT_BITS'(1));
  assign accept    = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    in_image_next     = in_image;
    epoch_next        = epoch;
    clear_addr_next   = clear_addr;
    next_free_next    = next_free;
    prefix_next       = prefix;
    img_root_next     = img_root;
    cur_pix_next      = cur_pix;
    last_pending_next = last_pending;
    probe_addr_next   = probe_addr;
    ram_we            = 1'b0;
    ram_waddr         = probe_addr;
    ram_wdata         = '0;
    ram_raddr         = probe_addr;
    push              = '0;

    case (state)
      lzw_pkg::S_CLEAR: begin
        // Wipe every slot back to the empty epoch.
        ram_we          = 1'b1;
        ram_waddr       = clear_addr;
        ram_wdata       = '0;
        clear_addr_next = clear_addr + 1'b1;
        if (clear_addr == '1) begin
          epoch_next = lzw_pkg::EPOCH_FIRST;
          state_next = lzw_pkg::S_IDLE;
        end
      end

      lzw_pkg::S_IDLE: begin
        if (accept) begin
          cur_pix_next      = pix_masked;
          last_pending_next = pix.last_pixel;
          if (!in_image) begin
            // Image start: send the clear code and seed the prefix.
            push.valid          = 1'b1;
            push.word.code      = clear_code;
            push.word.last_code = 1'b0;
            img_root_next       = root_now;
            next_free_next      = lzw_pkg::FREE_BITS'(clear_code) +
                                  lzw_pkg::FREE_BITS'(2);
            prefix_next         = lzw_pkg::CODE_BITS'(pix_masked);
            in_image_next       = 1'b1;
            state_next          = pix.last_pixel ? lzw_pkg::S_FLUSH : lzw_pkg::S_IDLE;
          end else begin
            ram_raddr       = lzw_pkg::dict_hash(prefix, pix_masked);
            probe_addr_next = ram_raddr;
            state_next      = lzw_pkg::S_PROBE;
          end
        end
      end

      lzw_pkg::S_PROBE: begin
        if (slot_used && slot.key == probe_key) begin
          // The extended string is known: it becomes the prefix.
          prefix_next = slot.code;
          state_next  = last_pending ? lzw_pkg::S_FLUSH : lzw_pkg::S_IDLE;
        end else if (slot_used) begin
          // Collision with another string: try the next slot.
          probe_addr_next = probe_addr + 1'b1;
          ram_raddr       = probe_addr_next;
        end else begin
          // Empty slot: the string is new. Emit the prefix and, unless the table is full, store it.
          push.valid          = 1'b1;
          push.word.code      = prefix;
          push.word.last_code = 1'b0;
          if (!table_full) begin
            ram_we          = 1'b1;
            ram_waddr       = probe_addr;
            ram_wdata.epoch = epoch;
            ram_wdata.key   = probe_key;
            ram_wdata.code  = next_free[lzw_pkg::CODE_BITS-1:0];
            next_free_next  = next_free + 1'b1;
          end
          prefix_next = lzw_pkg::CODE_BITS'(cur_pix);
          state_next  = last_pending ? lzw_pkg::S_FLUSH : lzw_pkg::S_IDLE;
        end
      end

      lzw_pkg::S_FLUSH: begin
        push.valid          = 1'b1;
        push.word.code      = prefix;
        push.word.last_code = 1'b0;
        state_next          = lzw_pkg::S_END;
      end

      lzw_pkg::S_END: begin
        // End of information closes the image. Once the epochs are used up
        // the table gets a real wipe before the next image.
        push.valid          = 1'b1;
        push.word.code      = clear_code + lzw_pkg::CODE_BITS'(1);
        push.word.last_code = 1'b1;
        in_image_next       = 1'b0;
        if (epoch == lzw_pkg::EPOCH_LAST) begin
          clear_addr_next = '0;
          state_next      = lzw_pkg::S_CLEAR;
        end else begin
          epoch_next = epoch + 1'b1;
          state_next = lzw_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lzw_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_image   <= 1'b0;
      epoch      <= lzw_pkg::EPOCH_EMPTY;
      clear_addr <= '0;
      next_free  <= '0;
      prefix     <= '0;
      root_bits  <= lzw_pkg::ROOT_RESET;
    end else begin
      in_image   <= in_image_next;
      epoch      <= epoch_next;
      clear_addr <= clear_addr_next;
      next_free  <= next_free_next;
      prefix     <= prefix_next;
      if (cfg_write) begin
        root_bits <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    img_root     <= img_root_next;
    cur_pix      <= cur_pix_next;
    last_pending <= last_pending_next;
    probe_addr   <= probe_addr_next;
  end

  lzw_ram #(
    .WIDTH(lzw_pkg::ENTRY_BITS),
    .DEPTH(lzw_pkg::HASH_DEPTH)
  ) u_dict (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lzw_out_fifo u_out (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .level(level),
    .out  (codes)
  );

`ifndef SYNTHESIS
  a_probe_in_image: assert property (@(posedge clk) disable iff (rst)
    (state == lzw_pkg::S_PROBE) |-> in_image)
    else $error("dictionary probe outside an image");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    table_full |-> (next_free[lzw_pkg::CODE_BITS-1:0] == '0))
    else $error("next free code beyond table size");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (state == lzw_pkg::S_END) |=> !in_image)
    else $error("image still open after end code");
`endif

endmodule

// ===== verif/tb_lzw_code_stream_encoder.sv =====
`timescale 1ns / 1ps

module tb_lzw_code_stream_encoder;
  import lzw_pkg::*;

  // A clearing pass of the hash table covers 2^(CODE_BITS+1) slots with no
  // pixel accepted. That happens after reset and after every fifteenth image,
  // so the watchdog allows several times that pass plus the longest stalls.
  localparam int WATCHDOG_LIMIT = 40000;
  // Cycles allowed after the last expected word before the block is taken as idle.
  localparam int SETTLE_CYCLES  = 64;
  localparam int RANDOM_ITEMS   = 300;

  // The scoreboard holds its own copy of the encoder state. Each accepted
  // pixel word is run through the predictor, which queues the code words
  // it causes; each accepted code word is checked against the oldest one.
  class lzw_scoreboard;
    code_word_t          code_q[$];
    int unsigned         string_codes[int unsigned];
    logic [ROOT_W-1:0]   root_reg;
    int unsigned         image_root;
    int unsigned         prefix;
    int unsigned         next_free;
    bit                  in_image;
    int                  errors;

    function new();
      root_reg   = ROOT_RESET;
      image_root = 8;
      prefix     = 0;
      next_free  = 0;
      in_image   = 1'b0;
      errors     = 0;
    endfunction

    function void set_root(logic [ROOT_W-1:0] value);
      root_reg = value;
    endfunction

    function int pending();
      return code_q.size();
    endfunction

    function void push_code(int unsigned code, bit last_code);
      code_word_t w;
      w.code      = CODE_BITS'(code);
      w.last_code = last_code;
      code_q.push_back(w);
    endfunction

    function void note_pixel(logic [PIX_BITS-1:0] pixel, logic last_pixel);
      int unsigned root_val;
      int unsigned clear_code;
      int unsigned pix_val;
      int unsigned key;
      if (!in_image) begin
        // The root size is sampled here and clamped into the legal range.
        root_val = root_reg;
        if (root_val < ROOT_MIN) begin
          image_root = ROOT_MIN;
        end else if (root_val > ROOT_MAX) begin
          image_root = ROOT_MAX;
        end else begin
          image_root = root_val;
        end
        clear_code = 1 << image_root;
        string_codes.delete();
        next_free = clear_code + 2;
        pix_val   = pixel & (clear_code - 1);
        push_code(clear_code, 1'b0);
        prefix    = pix_val;
        in_image  = 1'b1;
      end else begin
        clear_code = 1 << image_root;
        pix_val    = pixel & (clear_code - 1);
        key        = (prefix << PIX_BITS) | pix_val;
        if (string_codes.exists(key)) begin
          prefix = string_codes[key];
        end else begin
          push_code(prefix, 1'b0);
          // Once the table is full the dictionary stops growing.
          if (next_free < (1 << CODE_BITS)) begin
            string_codes[key] = next_free;
            next_free++;
          end
          prefix = pix_val;
        end
      end
      if (last_pixel) begin
        push_code(prefix, 1'b0);
        push_code(clear_code + 1, 1'b1);
        in_image = 1'b0;
      end
    endfunction

    function void check_code(logic [CODE_BITS-1:0] code, logic last_code);
      code_word_t want;
      if (code_q.size() == 0) begin
        $error("code word %0d (last_code %0b) arrived with none expected", code, last_code);
        errors++;
        return;
      end
      want = code_q.pop_front();
      if (code !== want.code) begin
        $error("code: expected %0d, actual %0d", want.code, code);
        errors++;
      end
      if (last_code !== want.last_code) begin
        $error("last_code: expected %0b, actual %0b", want.last_code, last_code);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [ROOT_W-1:0] cfg_data;

  lzw_pix_if  pix_ch ();
  lzw_code_if code_ch ();

  lzw_code_stream_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .pix       (pix_ch),
    .codes     (code_ch)
  );

  lzw_scoreboard sb = new();

  // Driver bookkeeping: whether valid is currently held high, how many words
  // remain in the current burst, and the root size last written.
  bit                valid_up;
  int                burst_left;
  logic [ROOT_W-1:0] root_setting;
  int                items_sent;
  int                idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every accepted pixel word goes to the predictor, and every accepted code
  // word is checked. Both are sampled at the edge, before any update lands.
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      sb.note_pixel(pix_ch.pixel_index, pix_ch.last_pixel);
    end
    if (!rst && code_ch.valid && code_ch.ready) begin
      sb.check_code(code_ch.code, code_ch.last_code);
    end
  end

  // The watchdog counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (code_ch.valid && code_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver runs its own pattern of stretches: always ready, a coin
  // flip per cycle, rarely ready, or a full stall of bounded length.
  initial begin
    int mode;
    int len;
    code_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = (mode == 3) ? $urandom_range(4, 40) : $urandom_range(8, 64);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: begin
            code_ch.ready <= 1'b1;
          end
          1: begin
            code_ch.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            code_ch.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            code_ch.ready <= 1'b0;
          end
        endcase
      end
    end
  end

  // Presents one pixel word and waits for it to be taken. The sender works
  // in bursts; when a burst runs out, valid drops for a random gap. A gap of
  // zero keeps valid high, so back-to-back words see no idle cycle at all.
  task automatic send_pixel(input logic [PIX_BITS-1:0] pixel, input logic last_pixel);
    int pick;
    int gap;
    if (!valid_up) begin
      pix_ch.valid <= 1'b1;
      valid_up = 1'b1;
    end
    pix_ch.pixel_index <= pixel;
    pix_ch.last_pixel  <= last_pixel;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        gap = 0;
      end else if (pick < 8) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(4, 20);
      end
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sends one image of n pixels drawn from a random window of the legal
  // color range. About one pixel in ten is a full eight-bit value, which
  // the block must cut down to the low root bits.
  task automatic send_image(input int n, input bit wide_alphabet);
    int unsigned root_val;
    int unsigned span;
    int unsigned alpha;
    int unsigned base;
    int unsigned p;
    root_val = root_setting;
    if (root_val < ROOT_MIN) begin
      root_val = ROOT_MIN;
    end else if (root_val > ROOT_MAX) begin
      root_val = ROOT_MAX;
    end
    span = 1 << root_val;
    if (wide_alphabet || $urandom_range(0, 1)) begin
      alpha = span;
    end else begin
      alpha = $urandom_range(1, 4);
    end
    base = $urandom_range(0, span - alpha);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        p = $urandom_range(0, 255);
      end else begin
        p = base + $urandom_range(0, alpha - 1);
      end
      send_pixel(p[PIX_BITS-1:0], k == n - 1);
    end
    items_sent += n;
  endtask

  // Brings the block to rest: valid drops, every expected word has to come
  // out, and then a few more cycles pass for any trailing table update.
  task automatic settle();
    if (valid_up) begin
      pix_ch.valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [ROOT_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_root(value);
    root_setting = value;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int len;
    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_data           <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel_index <= '0;
    pix_ch.last_pixel  <= 1'b0;
    valid_up     = 1'b0;
    burst_left   = 1;
    root_setting = ROOT_RESET;
    items_sent   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A one-pixel image at the reset root size gives the clear code, the
    // pixel's own code and the end code from a single word.
    send_pixel(8'd255, 1'b1);
    // Repeats of one color build longer strings that hit the dictionary.
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    settle();

    // Smallest root size; the all-ones index is wider than the root and
    // must fold down to color three.
    write_root(ROOT_W'(2));
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd2, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd3, 1'b1);
    settle();

    // Root sizes below the range act as the smallest one.
    write_root(ROOT_W'(0));
    send_pixel(8'd0, 1'b1);
    settle();
    write_root(ROOT_W'(1));
    send_pixel(8'd6, 1'b0);
    send_pixel(8'd1, 1'b1);
    settle();

    // Root sizes above the range act as the largest one.
    write_root(ROOT_W'(15));
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd127, 1'b1);
    settle();
    write_root(ROOT_W'(8));

    // Random images, mostly short, so that many image starts go by and the
    // table's epoch wraps around at least once. Root sizes are rewritten
    // at random between images, only once the block has gone quiet.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        write_root(ROOT_W'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 5) == 0) begin
        len = 1;
      end else begin
        len = $urandom_range(2, 30);
      end
      send_image(len, 1'b0);
    end

    settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lzw_pkg.sv
src/lzw_if.sv
src/lzw_ram.sv
src/lzw_out_fifo.sv
src/lzw_code_stream_encoder.sv
verif/tb_lzw_code_stream_encoder.sv
